// ===== rtl/ssr_pkg.sv =====
package ssr_pkg;

   // Stream and secret geometry
   localparam int MAX_SECRET = 32;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 6;
   localparam int IDX_W      = $clog2(MAX_SECRET);
   localparam int SECRET_W   = MAX_SECRET * BYTE_W;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int NUM_WORDS  = SECRET_W / CSR_DATA_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SECRET_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECRET_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECRET_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECRET_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SECRET_WORD_3 = 3'd4;

   // Item kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Replacement byte for a secret byte
   localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;

   typedef logic [BYTE_W-1:0] byte_type;

   // Settings seen by the datapath
   typedef struct packed {
      logic [LEN_W-1:0]    act_len;
      logic [SECRET_W-1:0] secret;
   } cfg_type;

endpackage

// ===== rtl/ssr_channels.sv =====
// Input channel: one stream byte or an end marker per item
interface ssr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// Result channel: one output byte per item
interface ssr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       any_redacted;

   modport source (output valid, output out_byte, output run_last, output any_redacted,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input any_redacted,
                   output ready);
endinterface

// ===== rtl/ssr_csr.sv =====
module ssr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output ssr_pkg::cfg_type                 cfg
);

   logic [ssr_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [ssr_pkg::CSR_DATA_W-1:0] word_ff [ssr_pkg::NUM_WORDS];
   logic [ssr_pkg::CSR_DATA_W-1:0] word_in [ssr_pkg::NUM_WORDS];

   // Decode register writes; unknown indexes are dropped
   always_comb begin
      len_in  = len_ff;
      word_in = word_ff;
      if (csr_wen) begin
         unique case (csr_index)
            ssr_pkg::CSR_SECRET_LENGTH: len_in = csr_wdata[ssr_pkg::LEN_W-1:0];
            ssr_pkg::CSR_SECRET_WORD_0: word_in[0] = csr_wdata;
            ssr_pkg::CSR_SECRET_WORD_1: word_in[1] = csr_wdata;
            ssr_pkg::CSR_SECRET_WORD_2: word_in[2] = csr_wdata;
            ssr_pkg::CSR_SECRET_WORD_3: word_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int w = 0; w < ssr_pkg::NUM_WORDS; w++) begin
            word_ff[w] <= '0;
         end
      end else begin
         len_ff  <= len_in;
         word_ff <= word_in;
      end
   end

   // Clamp the length and flatten the secret, byte 0 in the low bits
   always_comb begin
      if (len_ff > ssr_pkg::LEN_W'(ssr_pkg::MAX_SECRET)) begin
         cfg.act_len = ssr_pkg::LEN_W'(ssr_pkg::MAX_SECRET);
      end else begin
         cfg.act_len = len_ff;
      end
      for (int w = 0; w < ssr_pkg::NUM_WORDS; w++) begin
         cfg.secret[w*ssr_pkg::CSR_DATA_W +: ssr_pkg::CSR_DATA_W] = word_ff[w];
      end
   end

endmodule

// ===== rtl/ssr_match.sv =====
module ssr_match (
   input  logic [ssr_pkg::SECRET_W-1:0] window_flat,
   input  logic [ssr_pkg::IDX_W-1:0]    offset,
   input  ssr_pkg::cfg_type             cfg,
   output logic                         hit
);

   logic [ssr_pkg::SECRET_W-1:0]   aligned;
   logic [ssr_pkg::MAX_SECRET-1:0] byte_ok;

   // Align the tail of the window to the secret and compare the bytes in use
   always_comb begin
      aligned = window_flat >> {offset, 3'b000};
      for (int k = 0; k < ssr_pkg::MAX_SECRET; k++) begin
         byte_ok[k] = (aligned[k*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W] ==
                       cfg.secret[k*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W])
                      || (ssr_pkg::LEN_W'(k) >= cfg.act_len);
      end
      hit = (&byte_ok) && (cfg.act_len != '0);
   end

endmodule

// ===== rtl/ssr_engine.sv =====
module ssr_engine (
   input  logic              clock,
   input  logic              reset,
   input  ssr_pkg::cfg_type  cfg,
   ssr_req_if.sink           req_chan,
   ssr_rsp_if.source         rsp_chan
);

   // Input register
   logic                  in_vld_ff, in_vld_in;
   logic                  in_kind_ff, in_kind_in;
   ssr_pkg::byte_type     in_byte_ff, in_byte_in;

   // Hold window and sequencing state
   ssr_pkg::byte_type           win_ff [ssr_pkg::MAX_SECRET];
   ssr_pkg::byte_type           win_in [ssr_pkg::MAX_SECRET];
   logic [ssr_pkg::LEN_W-1:0]   cnt_ff, cnt_in;
   logic [ssr_pkg::LEN_W-1:0]   stars_ff, stars_in;
   logic                        flag_ff, flag_in;

   // Result register
   logic                  out_vld_ff, out_vld_in;
   ssr_pkg::byte_type     out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_red_ff, out_red_in;

   ssr_pkg::byte_type            vw [ssr_pkg::MAX_SECRET];
   logic [ssr_pkg::SECRET_W-1:0] vw_flat;
   logic [ssr_pkg::LEN_W-1:0]    n_cur;
   logic [ssr_pkg::LEN_W-1:0]    offset;
   logic                         hit;
   logic                         item_hit;
   logic                         red_item;
   logic                         advance;
   logic                         consume;
   logic                         emit;
   ssr_pkg::byte_type            emit_byte;
   logic                         emit_last;
   logic                         emit_red;

   // Window as it stands with the pending byte placed after the held ones
   always_comb begin
      for (int k = 0; k < ssr_pkg::MAX_SECRET; k++) begin
         vw[k] = (cnt_ff == ssr_pkg::LEN_W'(k)) ? in_byte_ff : win_ff[k];
         vw_flat[k*ssr_pkg::BYTE_W +: ssr_pkg::BYTE_W] = vw[k];
      end
      n_cur  = cnt_ff + ssr_pkg::LEN_W'(1);
      offset = n_cur - cfg.act_len;
   end

   // Compare the last act_len bytes against the secret ahead of any release
   ssr_match u_match (
      .window_flat (vw_flat),
      .offset      (offset[ssr_pkg::IDX_W-1:0]),
      .cfg         (cfg),
      .hit         (hit)
   );

   assign item_hit = hit && (n_cur >= cfg.act_len);
   assign red_item = flag_ff | item_hit;
   assign advance  = !out_vld_ff || rsp_chan.ready;

   // Pick at most one result per cycle: stars first, then for the held item a flush, a release, a match or an append
   always_comb begin
      win_in    = win_ff;
      cnt_in    = cnt_ff;
      stars_in  = stars_ff;
      flag_in   = flag_ff;
      consume   = 1'b0;
      emit      = 1'b0;
      emit_byte = vw[0];
      emit_last = 1'b0;
      emit_red  = flag_ff;

      if (stars_ff != '0) begin
         if (advance) begin
            emit      = 1'b1;
            emit_byte = ssr_pkg::STAR_BYTE;
            emit_last = (stars_ff == ssr_pkg::LEN_W'(1));
            stars_in  = stars_ff - ssr_pkg::LEN_W'(1);
         end
      end else if (in_vld_ff) begin
         if (in_kind_ff == ssr_pkg::KIND_END) begin
            // Flush one held byte per cycle while the result slot is free
            if (cnt_ff == '0) begin
               consume = 1'b1;
            end else if (advance) begin
               emit      = 1'b1;
               emit_last = (cnt_ff == ssr_pkg::LEN_W'(1));
               consume   = (cnt_ff == ssr_pkg::LEN_W'(1));
               cnt_in    = cnt_ff - ssr_pkg::LEN_W'(1);
               for (int k = 0; k < ssr_pkg::MAX_SECRET - 1; k++) begin
                  win_in[k] = vw[k+1];
               end
            end
         end else if (n_cur > cfg.act_len) begin
            // Release bytes beyond the secret length
            if (advance) begin
               emit     = 1'b1;
               emit_red = red_item;
               for (int k = 0; k < ssr_pkg::MAX_SECRET - 1; k++) begin
                  win_in[k] = vw[k+1];
               end
               if (cnt_ff == '0) begin
                  consume   = 1'b1;
                  emit_last = 1'b1;
               end else begin
                  cnt_in = cnt_ff - ssr_pkg::LEN_W'(1);
               end
            end
         end else if (n_cur == cfg.act_len) begin
            // Full window: replace on a match, else release the oldest byte
            if (advance) begin
               emit    = 1'b1;
               consume = 1'b1;
               if (item_hit) begin
                  emit_byte = ssr_pkg::STAR_BYTE;
                  emit_last = (cfg.act_len == ssr_pkg::LEN_W'(1));
                  emit_red  = 1'b1;
                  stars_in  = cfg.act_len - ssr_pkg::LEN_W'(1);
                  cnt_in    = '0;
                  flag_in   = 1'b1;
               end else begin
                  emit_last = 1'b1;
                  for (int k = 0; k < ssr_pkg::MAX_SECRET - 1; k++) begin
                     win_in[k] = vw[k+1];
                  end
               end
            end
         end else begin
            // Window not yet full: hold the byte
            consume = 1'b1;
            win_in  = vw;
            cnt_in  = n_cur;
         end
      end
   end

   // Input register takes a new item whenever it is empty or being drained
   assign req_chan.ready = !in_vld_ff || consume;

   always_comb begin
      in_kind_in = in_kind_ff;
      in_byte_in = in_byte_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_vld_in  = 1'b1;
         in_kind_in = req_chan.kind;
         in_byte_in = req_chan.data_byte;
      end else if (consume) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   // Result register loads whenever its slot frees up
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_red_in  = out_red_ff;
      if (advance) begin
         out_vld_in = emit;
         if (emit) begin
            out_byte_in = emit_byte;
            out_last_in = emit_last;
            out_red_in  = emit_red;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         cnt_ff     <= '0;
         stars_ff   <= '0;
         flag_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         cnt_ff     <= cnt_in;
         stars_ff   <= stars_in;
         flag_ff    <= flag_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff  <= in_kind_in;
      in_byte_ff  <= in_byte_in;
      win_ff      <= win_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_red_ff  <= out_red_in;
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.out_byte     = out_byte_ff;
   assign rsp_chan.run_last     = out_last_ff;
   assign rsp_chan.any_redacted = out_red_ff;

endmodule

// ===== rtl/stream_secret_redactor_unit.sv =====
// Streaming secret redactor. Bytes enter on req_chan; every leftmost, non-overlapping
// occurrence of the configured secret (1 to 32 bytes, length 0 passes bytes through)
// leaves rsp_chan as the same number of '*' bytes, and all other bytes leave unchanged
// and in order. The newest length-1 bytes are held back until they can no longer start
// a match; an end item flushes them. run_last marks the last byte caused by an item and
// any_redacted is the sticky flag after that item. The block delivers one result per
// cycle while rsp_chan is ready, through a single result register. An item that yields
// zero or one byte (the steady state of a stream) keeps up with that rate; a match's
// star run and a flush of held bytes go out one byte at a time before the next item is
// handled. A byte passes the input register and then the result register on its way
// to rsp_chan. The input register accepts a new item while a result waits. Write the
// csr_ registers only while the stream is idle.
module stream_secret_redactor_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   ssr_req_if.sink                         req_chan,
   ssr_rsp_if.source                       rsp_chan
);

   ssr_pkg::cfg_type cfg;

   // Configuration registers
   ssr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Hold window, match and result sequencing
   ssr_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/sv/stream_secret_redactor_unit_tb.sv =====
`timescale 1ns / 100ps

module stream_secret_redactor_unit_tb;
   import ssr_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned RANDOM_ITEMS  = 470;
   localparam int unsigned QUIET_TAIL    = 70;

   // Index with no register behind it: a write must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd5;

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_op_type;

   // One directed row: a register write or an item, with an optional typed-in result
   typedef struct packed {
      row_op_type             op;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  value;
      logic                   kind;
      byte_type               data;
      logic                   has_golden;
      logic                   golden_one;
      byte_type               golden_byte;
      logic                   golden_flag;
   } stim_row_type;

   typedef struct packed {
      byte_type out_byte;
      logic     run_last;
      logic     any_redacted;
   } redacted_byte_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ssr_req_if req_chan ();
   ssr_rsp_if rsp_chan ();

   stream_secret_redactor_unit uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always #1 clock = ~clock;

   // Predictor state: settings, hold window and sticky flag
   logic [LEN_W-1:0]      secret_len_reg = '0;
   logic [CSR_DATA_W-1:0] secret_words [NUM_WORDS];
   byte_type              held_bytes [MAX_SECRET];
   int unsigned           held_total = 0;
   logic                  sticky_redacted = 1'b0;
   byte_type              released_now [$];

   redacted_byte_type pending_bytes [$];
   stim_row_type      directed_rows [$];
   redacted_byte_type head_byte;

   int          error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   bit          idle_on = 1'b1;
   bit          stream_busy = 1'b0;

   function automatic int unsigned active_length();
      return (secret_len_reg > MAX_SECRET) ? MAX_SECRET : int'(secret_len_reg);
   endfunction

   function automatic byte_type secret_at(int unsigned i);
      return secret_words[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic void apply_setting(logic [CSR_IDX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_SECRET_LENGTH: secret_len_reg = val[LEN_W-1:0];
         CSR_SECRET_WORD_0: secret_words[0] = val;
         CSR_SECRET_WORD_1: secret_words[1] = val;
         CSR_SECRET_WORD_2: secret_words[2] = val;
         CSR_SECRET_WORD_3: secret_words[3] = val;
         default: ;
      endcase
   endfunction

   // Release the oldest held byte unchanged and shift the window down
   function automatic void release_oldest();
      int i;
      if (held_total == 0) return;
      if (released_now.size() < MAX_SECRET) begin
         released_now.insert(released_now.size(), held_bytes[0]);
      end
      for (i = 1; i < held_total; i++) held_bytes[i-1] = held_bytes[i];
      held_total--;
   endfunction

   // Advance the window by one item and collect the bytes it lets out
   function automatic void predict_redaction(logic k, byte_type d);
      int unsigned len_now;
      int          i;
      bit          hit;
      len_now = active_length();
      released_now.delete();
      if (k == KIND_END) begin
         while (held_total > 0) release_oldest();
      end else begin
         if (held_total >= MAX_SECRET) release_oldest();
         held_bytes[held_total] = d;
         held_total++;
         while (held_total > len_now) release_oldest();
         if (len_now > 0 && held_total == len_now) begin
            hit = 1'b1;
            for (i = 0; i < len_now; i++) begin
               if (held_bytes[i] != secret_at(i)) hit = 1'b0;
            end
            if (hit) begin
               for (i = 0; i < len_now; i++) begin
                  if (released_now.size() < MAX_SECRET) begin
                     released_now.insert(released_now.size(), STAR_BYTE);
                  end
               end
               held_total = 0;
               sticky_redacted = 1'b1;
            end else begin
               release_oldest();
            end
         end
      end
   endfunction

   function automatic void put_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r = '0;
      r.op = ROW_WRITE;
      r.index = idx;
      r.value = val;
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic void put_item(logic k, byte_type d);
      stim_row_type r;
      r = '0;
      r.op = ROW_ITEM;
      r.kind = k;
      r.data = d;
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic void put_checked(logic k, byte_type d, logic one, byte_type gb,
                                       logic gf);
      stim_row_type r;
      r = '0;
      r.op = ROW_ITEM;
      r.kind = k;
      r.data = d;
      r.has_golden = 1'b1;
      r.golden_one = one;
      r.golden_byte = gb;
      r.golden_flag = gf;
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // Present one item, hold it until taken, then predict its bytes
   task automatic send_item(input logic k, input byte_type d, input bit from_model);
      redacted_byte_type entry;
      int                i;
      csr_wen <= 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= k;
      req_chan.data_byte <= d;
      do @(posedge clock); while (!req_chan.ready);
      stream_busy = 1'b1;
      predict_redaction(k, d);
      if (from_model) begin
         for (i = 0; i < released_now.size(); i++) begin
            entry.out_byte     = released_now[i];
            entry.run_last     = (i == released_now.size() - 1);
            entry.any_redacted = sticky_redacted;
            pending_bytes.insert(pending_bytes.size(), entry);
         end
      end
   endtask

   // Drop valid, drain every expected byte, then let the block go quiet
   task automatic settle_stream();
      if (stream_busy) begin
         req_chan.valid <= 1'b0;
         while (pending_bytes.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         stream_busy = 1'b0;
      end
   endtask

   task automatic write_setting(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DATA_W-1:0] val);
      settle_stream();
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_setting(idx, val);
   endtask

   // Result side: ready, with random stall bursts while idling is on
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Check each taken byte against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected byte: out_byte %h run_last %b any_redacted %b",
                   rsp_chan.out_byte, rsp_chan.run_last, rsp_chan.any_redacted);
            error_count++;
         end else begin
            head_byte = pending_bytes.pop_front();
            if (rsp_chan.out_byte !== head_byte.out_byte) begin
               $error("out_byte: expected %h, got %h", head_byte.out_byte, rsp_chan.out_byte);
               error_count++;
            end
            if (rsp_chan.run_last !== head_byte.run_last) begin
               $error("run_last: expected %b, got %b", head_byte.run_last, rsp_chan.run_last);
               error_count++;
            end
            if (rsp_chan.any_redacted !== head_byte.any_redacted) begin
               $error("any_redacted: expected %b, got %b", head_byte.any_redacted,
                      rsp_chan.any_redacted);
               error_count++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL stream_secret_redactor_unit");
         $finish;
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] fresh_words [NUM_WORDS];
      redacted_byte_type     golden;
      stim_row_type          row;
      int unsigned           random_sent, phase_goal, phase_sent;
      int unsigned           lim, span, choice, mode, base, len_pick, r, i;
      bit                    keep_secret;

      for (i = 0; i < NUM_WORDS; i++) secret_words[i] = '0;
      for (i = 0; i < MAX_SECRET; i++) held_bytes[i] = '0;

      reset              <= 1'b1;
      csr_wen            <= 1'b0;
      csr_index          <= CSR_SECRET_LENGTH;
      csr_wdata          <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.kind      <= KIND_DATA;
      req_chan.data_byte <= '0;

      // Pass-through after reset: byte extremes, then an end on an empty window
      put_checked(KIND_DATA, 8'h00, 1'b1, 8'h00, 1'b0);
      put_checked(KIND_DATA, 8'hFF, 1'b1, 8'hFF, 1'b0);
      put_checked(KIND_END,  8'hA5, 1'b0, 8'h00, 1'b0);
      // One-byte secret; a write to an unused index must change nothing
      put_write(CSR_SECRET_LENGTH, 64'd1);
      put_write(CSR_SECRET_WORD_0, 64'h41);
      put_write(CSR_UNUSED_INDEX, '1);
      put_checked(KIND_DATA, 8'h41, 1'b1, STAR_BYTE, 1'b1);
      put_checked(KIND_DATA, 8'h40, 1'b1, 8'h40, 1'b1);
      // Length above the limit acts as the limit; end flushes the held bytes
      put_write(CSR_SECRET_LENGTH, 64'd63);
      put_write(CSR_SECRET_WORD_0, '1);
      put_write(CSR_SECRET_WORD_1, '1);
      put_write(CSR_SECRET_WORD_2, '1);
      put_write(CSR_SECRET_WORD_3, '1);
      put_item(KIND_DATA, 8'hFF);
      put_item(KIND_DATA, 8'hFF);
      put_item(KIND_DATA, 8'h00);
      put_item(KIND_END, 8'h00);
      // Hold three bytes, then shrink the length under them
      put_write(CSR_SECRET_LENGTH, 64'd4);
      put_write(CSR_SECRET_WORD_0, 64'h64636261);
      put_item(KIND_DATA, 8'h61);
      put_item(KIND_DATA, 8'h62);
      put_item(KIND_DATA, 8'h63);
      put_write(CSR_SECRET_LENGTH, 64'd2);
      put_write(CSR_SECRET_WORD_0, 64'h7978);
      put_item(KIND_DATA, 8'h78);
      put_item(KIND_DATA, 8'h78);
      put_item(KIND_DATA, 8'h79);
      put_item(KIND_DATA, 8'h78);
      // Length zero with a byte still held
      put_write(CSR_SECRET_LENGTH, 64'd0);
      put_item(KIND_DATA, 8'h55);
      put_checked(KIND_END, 8'hFF, 1'b0, 8'h00, 1'b0);
      // Leftmost match after a false start on a repeated byte
      put_write(CSR_SECRET_LENGTH, 64'd3);
      put_write(CSR_SECRET_WORD_0, 64'h626161);
      put_item(KIND_DATA, 8'h61);
      put_item(KIND_DATA, 8'h61);
      put_item(KIND_DATA, 8'h61);
      put_item(KIND_DATA, 8'h62);
      put_item(KIND_DATA, 8'h61);
      put_item(KIND_END, 8'h00);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (r = 0; r < directed_rows.size(); r++) begin
         row = directed_rows[r];
         if (row.op == ROW_WRITE) begin
            write_setting(row.index, row.value);
         end else begin
            send_item(row.kind, row.data, !row.has_golden);
            if (row.has_golden && row.golden_one) begin
               golden.out_byte     = row.golden_byte;
               golden.run_last     = 1'b1;
               golden.any_redacted = row.golden_flag;
               pending_bytes.insert(pending_bytes.size(), golden);
            end
         end
      end

      // Random phases: new settings, then streams built around the secret
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         idle_on = (RANDOM_ITEMS - random_sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);

         choice = $urandom_range(0, 9);
         if (choice == 0)      len_pick = 0;
         else if (choice == 1) len_pick = MAX_SECRET;
         else if (choice == 2) len_pick = $urandom_range(MAX_SECRET + 1, 63);
         else                  len_pick = $urandom_range(1, 8);
         keep_secret = ($urandom_range(0, 3) == 0);

         mode = $urandom_range(0, 7);
         base = $urandom_range(0, 254);
         for (i = 0; i < MAX_SECRET; i++) begin
            if (mode < 4) begin
               fresh_words[i / 8][(i % 8) * 8 +: 8] = 8'(base + $urandom_range(0, 1));
            end else if (mode < 6) begin
               fresh_words[i / 8][(i % 8) * 8 +: 8] = 8'($urandom_range(0, 255));
            end else if (mode == 6) begin
               fresh_words[i / 8][(i % 8) * 8 +: 8] = 8'h00;
            end else begin
               fresh_words[i / 8][(i % 8) * 8 +: 8] = 8'hFF;
            end
         end

         write_setting(CSR_SECRET_LENGTH, CSR_DATA_W'(len_pick));
         if (!keep_secret) begin
            write_setting(CSR_SECRET_WORD_0, fresh_words[0]);
            write_setting(CSR_SECRET_WORD_1, fresh_words[1]);
            write_setting(CSR_SECRET_WORD_2, fresh_words[2]);
            write_setting(CSR_SECRET_WORD_3, fresh_words[3]);
         end

         lim = active_length();
         phase_goal = $urandom_range(30, 70);
         phase_sent = 0;
         while (phase_sent < phase_goal) begin
            // Stop idling once the run reaches its tail
            if (random_sent + phase_sent + QUIET_TAIL >= RANDOM_ITEMS) idle_on = 1'b0;
            choice = $urandom_range(0, 99);
            if (choice < 30 && lim > 0) begin
               // whole secret
               for (i = 0; i < lim; i++) send_item(KIND_DATA, secret_at(i), 1'b1);
               phase_sent += lim;
            end else if (choice < 45 && lim > 1) begin
               // broken-off prefix
               span = $urandom_range(1, lim - 1);
               for (i = 0; i < span; i++) send_item(KIND_DATA, secret_at(i), 1'b1);
               phase_sent += span;
            end else if (choice < 80 && lim > 0) begin
               send_item(KIND_DATA, secret_at($urandom_range(0, lim - 1)), 1'b1);
               phase_sent++;
            end else if (choice < 95) begin
               send_item(KIND_DATA, 8'($urandom_range(0, 255)), 1'b1);
               phase_sent++;
            end else begin
               send_item(KIND_END, 8'($urandom_range(0, 255)), 1'b1);
               phase_sent++;
            end
         end
         if (random_sent + phase_sent + QUIET_TAIL >= RANDOM_ITEMS) idle_on = 1'b0;
         if ($urandom_range(0, 2) == 0) begin
            send_item(KIND_END, 8'($urandom_range(0, 255)), 1'b1);
            phase_sent++;
         end
         random_sent += phase_sent;
      end

      // Flush whatever is still held and drain
      send_item(KIND_END, 8'h00, 1'b1);
      settle_stream();

      if (error_count == 0) begin
         $display("PASS stream_secret_redactor_unit");
      end else begin
         $display("FAIL stream_secret_redactor_unit");
      end
      $finish;
   end

endmodule
